/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ptts_pkg.sv */
// Types and constants of the periodic task table scheduler.
package ptts_pkg;

  localparam int TIME_W = 32;
  localparam int ID_W = 8;
  localparam int LEFT_W = 9;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  localparam logic [1:0] KIND_ADD_OK = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_FIRE = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] period_us;
    logic [TIME_W-1:0] offset_us;
    logic [TIME_W-1:0] max_calls;
    logic [TIME_W-1:0] lifetime_us;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] call_count;
    logic              retired;
    logic [LEFT_W-1:0] tasks_left;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] offset;
    logic [TIME_W-1:0] call_limit;
    logic [TIME_W-1:0] calls;
    logic [TIME_W-1:0] lifetime;
    logic [TIME_W-1:0] last_fire;
    logic [TIME_W-1:0] birth;
  } entry_t;

  typedef struct packed {
    logic   due;
    logic   retired;
    entry_t upd;
  } eval_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P1_READ,
    ST_P1_EVAL,
    ST_P2_READ,
    ST_P2_EVAL,
    ST_END
  } state_t;

endpackage

/* hw/rtl/periodic_task_table_scheduler.sv */
// Periodic task table scheduler: sequencer around the task table memory.
//
// An add returns one response. A scan over a table of n entries reads every
// entry twice before its end response, and a stall on the response side can
// hold it up: the table sits in a single-read-port memory and is walked twice,
// with a read state and an evaluate state per entry each time. The first walk
// counts the surviving entries, so that every fire response already carries
// the final table size; the second walk emits the fire responses, writes the
// updated entries back and compacts the table in place. Fire responses come
// in table order, followed by one end response. No clearing pass follows
// reset.
module periodic_task_table_scheduler #(
  parameter int NUM_TASKS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  ptts_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output ptts_pkg::rsp_t   rsp
);
  import ptts_pkg::*;

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_TASKS);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  kept, kept_next;
  logic [CNT_W-1:0]  wr_ptr, wr_ptr_next;
  logic [TIME_W-1:0] scan_now, scan_now_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic              out_free;
  logic              req_fire;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  entry_t            mem_wr_data;
  logic              mem_rd_en;
  entry_t            mem_rd_data;
  eval_t             ev;
  entry_t            new_entry;

  assign out_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && out_free;
  assign req_fire = req_valid && req_ready;

  ptts_mem #(
    .DEPTH (NUM_TASKS),
    .ADDR_W(IDX_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(idx[IDX_W-1:0]),
    .rd_data(mem_rd_data)
  );

  ptts_eval u_eval (
    .ent(mem_rd_data),
    .now(scan_now),
    .res(ev)
  );

  always_comb begin
    new_entry.id = req.task_id;
    new_entry.period = req.period_us;
    new_entry.offset = req.offset_us;
    new_entry.call_limit = req.max_calls;
    new_entry.calls = '0;
    new_entry.lifetime = req.lifetime_us;
    new_entry.last_fire = req.now;
    new_entry.birth = req.now;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire && (req.command == CMD_SCAN)) begin
          state_next = ST_P1_READ;
        end
      end
      ST_P1_READ: begin
        state_next = (idx == count) ? ST_P2_READ : ST_P1_EVAL;
      end
      ST_P1_EVAL: begin
        state_next = ST_P1_READ;
      end
      ST_P2_READ: begin
        state_next = (idx == count) ? ST_END : ST_P2_EVAL;
      end
      ST_P2_EVAL: begin
        if (!ev.due || out_free) begin
          state_next = ST_P2_READ;
        end
      end
      ST_END: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_next = count;
    idx_next = idx;
    kept_next = kept;
    wr_ptr_next = wr_ptr;
    scan_now_next = scan_now;
    mem_wr_en = 1'b0;
    mem_wr_addr = wr_ptr[IDX_W-1:0];
    mem_wr_data = ev.upd;
    mem_rd_en = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next = rsp;

    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.command == CMD_SCAN) begin
            scan_now_next = req.now;
            idx_next = '0;
            kept_next = '0;
          end else begin
            rsp_valid_next = 1'b1;
            rsp_next.fired_id = req.task_id;
            rsp_next.call_count = '0;
            rsp_next.retired = 1'b0;
            rsp_next.last = 1'b1;
            if (count == FULL_CNT) begin
              rsp_next.kind = KIND_ADD_FULL;
              rsp_next.tasks_left = LEFT_W'(count);
            end else begin
              mem_wr_en = 1'b1;
              mem_wr_addr = count[IDX_W-1:0];
              mem_wr_data = new_entry;
              count_next = count + CNT_W'(1);
              rsp_next.kind = KIND_ADD_OK;
              rsp_next.tasks_left = LEFT_W'(count_next);
            end
          end
        end
      end
      ST_P1_READ: begin
        if (idx == count) begin
          idx_next = '0;
          wr_ptr_next = '0;
        end else begin
          mem_rd_en = 1'b1;
        end
      end
      ST_P1_EVAL: begin
        if (!(ev.due && ev.retired)) begin
          kept_next = kept + CNT_W'(1);
        end
        idx_next = idx + CNT_W'(1);
      end
      ST_P2_READ: begin
        if (idx != count) begin
          mem_rd_en = 1'b1;
        end
      end
      ST_P2_EVAL: begin
        if (!ev.due || out_free) begin
          // Survivors slide down to the write pointer; the read side is never behind it.
          if (!(ev.due && ev.retired)) begin
            mem_wr_en = 1'b1;
            mem_wr_data = ev.due ? ev.upd : mem_rd_data;
            wr_ptr_next = wr_ptr + CNT_W'(1);
          end
          if (ev.due) begin
            rsp_valid_next = 1'b1;
            rsp_next.kind = KIND_FIRE;
            rsp_next.fired_id = mem_rd_data.id;
            rsp_next.call_count = ev.upd.calls;
            rsp_next.retired = ev.retired;
            rsp_next.tasks_left = LEFT_W'(kept);
            rsp_next.last = 1'b0;
          end
          idx_next = idx + CNT_W'(1);
        end
      end
      ST_END: begin
        if (out_free) begin
          count_next = kept;
          rsp_valid_next = 1'b1;
          rsp_next.kind = KIND_END;
          rsp_next.fired_id = '0;
          rsp_next.call_count = '0;
          rsp_next.retired = 1'b0;
          rsp_next.tasks_left = LEFT_W'(kept);
          rsp_next.last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx <= '0;
      kept <= '0;
      wr_ptr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx <= idx_next;
      kept <= kept_next;
      wr_ptr <= wr_ptr_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_now <= scan_now_next;
    rsp <= rsp_next;
  end

endmodule

/* hw/rtl/ptts_mem.sv */
// Task table memory: one write port, one read port with registered read data.
module ptts_mem #(
  parameter int DEPTH = 16,
  parameter int ADDR_W = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  ptts_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output ptts_pkg::entry_t     rd_data
);
  import ptts_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/ptts_eval.sv */
// Due test, fire update and retirement test for one table entry.
module ptts_eval (
  input  ptts_pkg::entry_t              ent,
  input  logic [ptts_pkg::TIME_W-1:0]   now,
  output ptts_pkg::eval_t               res
);
  import ptts_pkg::*;

  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] calls_inc;
  logic              has_offset;
  logic              limit_hit;
  logic              life_hit;

  always_comb begin
    since = now - ent.last_fire;
    age = now - ent.birth;
    calls_inc = ent.calls + TIME_W'(1);
    has_offset = (ent.offset != '0);
    // An offset restart moves birth to now, so the age seen is zero.
    limit_hit = (ent.call_limit != '0) && (calls_inc >= ent.call_limit);
    life_hit = !has_offset && (ent.lifetime != '0) && (age >= ent.lifetime);

    res.due = (since >= ent.period) && (since >= ent.offset);
    res.retired = limit_hit || life_hit;
    res.upd = ent;
    res.upd.calls = calls_inc;
    if (has_offset) begin
      res.upd.offset = '0;
      res.upd.birth = now;
      res.upd.last_fire = now;
    end else begin
      res.upd.last_fire = ent.last_fire + ent.period;
    end
  end

endmodule

/* hw/rtl/ptts_checker.sv */
// Port-level checks of the periodic task table scheduler, bound to the top level.
`include "assert_macros.svh"

module ptts_checker #(
  parameter int NUM_TASKS = 16
) (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input ptts_pkg::req_t  req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input ptts_pkg::rsp_t  rsp
);
  import ptts_pkg::*;

  // A stalled response stays on the port.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

  // An accepted add answers with a single closing response in the next cycle.
  `ASSERT_NEXT(a_add_answer, clk, rst, req_valid && req_ready && (req.command == CMD_ADD), rsp_valid && rsp.last && (rsp.kind == KIND_ADD_OK || rsp.kind == KIND_ADD_FULL), "add request not answered")

  // Fire responses never close a command, every other kind does.
  `ASSERT_IMPL(a_fire_not_last, clk, rst, rsp_valid, (rsp.kind == KIND_FIRE) != rsp.last, "last flag disagrees with kind")

  // The table never reports more tasks than it can hold.
  `ASSERT_IMPL(a_left_range, clk, rst, rsp_valid, rsp.tasks_left <= LEFT_W'(NUM_TASKS), "table size out of range")

endmodule

bind periodic_task_table_scheduler ptts_checker #(
  .NUM_TASKS(NUM_TASKS)
) u_ptts_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

/* verif/tb.sv */
// Testbench of the periodic task table scheduler: random paced traffic, table predictor, checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptts_pkg::*;

  localparam int NUM_TASKS = 16;
  localparam int RANDOM_ITEMS = 105;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  periodic_task_table_scheduler #(
    .NUM_TASKS(NUM_TASKS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  req_t cmd_backlog[$];
  rsp_t awaited_rsp[$];

  // Mirror of the task table.
  entry_t task_tbl[NUM_TASKS];
  int tbl_count = 0;

  int n_errors = 0;
  int n_adds = 0;
  int n_scans = 0;
  int n_refused = 0;
  int n_fires = 0;
  int n_retired = 0;
  int n_issued = 0;
  int n_rsp = 0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  // Every third stretch of twenty handshakes runs with no idling at all.
  function automatic int pause_for(int seq);
    if ((seq / 20) % 3 == 2) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic req_t add_cmd(logic [31:0] at, logic [7:0] id, logic [31:0] per,
                                   logic [31:0] off, logic [31:0] lim, logic [31:0] life);
    req_t r;
    r.command = CMD_ADD;
    r.now = at;
    r.task_id = id;
    r.period_us = per;
    r.offset_us = off;
    r.max_calls = lim;
    r.lifetime_us = life;
    return r;
  endfunction

  // The add fields of a scan are don't-care, so they carry random bits.
  function automatic req_t scan_cmd(logic [31:0] at);
    req_t r;
    r = add_cmd(at, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
    r.command = CMD_SCAN;
    return r;
  endfunction

  // A task that fires at a reachable pace and usually retires sooner or later.
  function automatic req_t workload_add(logic [31:0] at);
    logic [31:0] off, lim, life;
    off = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(1, 400)) : 32'd0;
    lim = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
    life = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(50, 2000));
    return add_cmd(at, 8'($urandom), 32'($urandom_range(0, 300)), off, lim, life);
  endfunction

  function automatic void apply_command(req_t r);
    rsp_t o;
    rsp_t fires[$];
    logic [31:0] since;
    bit [NUM_TASKS-1:0] doomed;
    int kept;
    o = '0;
    doomed = '0;
    if (r.command == CMD_ADD) begin
      n_adds++;
      o.fired_id = r.task_id;
      o.last = 1'b1;
      if (tbl_count >= NUM_TASKS) begin
        n_refused++;
        o.kind = KIND_ADD_FULL;
      end else begin
        task_tbl[tbl_count].id = r.task_id;
        task_tbl[tbl_count].period = r.period_us;
        task_tbl[tbl_count].offset = r.offset_us;
        task_tbl[tbl_count].call_limit = r.max_calls;
        task_tbl[tbl_count].lifetime = r.lifetime_us;
        task_tbl[tbl_count].calls = '0;
        task_tbl[tbl_count].last_fire = r.now;
        task_tbl[tbl_count].birth = r.now;
        tbl_count++;
        o.kind = KIND_ADD_OK;
      end
      o.tasks_left = LEFT_W'(tbl_count);
      awaited_rsp.push_back(o);
    end else begin
      n_scans++;
      for (int i = 0; i < tbl_count; i++) begin
        since = r.now - task_tbl[i].last_fire;
        if (since >= task_tbl[i].period && since >= task_tbl[i].offset) begin
          task_tbl[i].calls = task_tbl[i].calls + 32'd1;
          if (task_tbl[i].offset == '0) begin
            task_tbl[i].last_fire = task_tbl[i].last_fire + task_tbl[i].period;
          end else begin
            // A task leaving its start delay restarts its clock and its age at now.
            task_tbl[i].offset = '0;
            task_tbl[i].birth = r.now;
            task_tbl[i].last_fire = r.now;
          end
          doomed[i] = (task_tbl[i].call_limit != '0 &&
                       task_tbl[i].calls >= task_tbl[i].call_limit) ||
                      (task_tbl[i].lifetime != '0 &&
                       32'(r.now - task_tbl[i].birth) >= task_tbl[i].lifetime);
          o = '0;
          o.kind = KIND_FIRE;
          o.fired_id = task_tbl[i].id;
          o.call_count = task_tbl[i].calls;
          o.retired = doomed[i];
          fires.push_back(o);
          n_fires++;
          if (doomed[i]) n_retired++;
        end
      end
      kept = 0;
      for (int i = 0; i < tbl_count; i++) begin
        if (!doomed[i]) begin
          task_tbl[kept] = task_tbl[i];
          kept++;
        end
      end
      tbl_count = kept;
      foreach (fires[k]) begin
        fires[k].tasks_left = LEFT_W'(tbl_count);
        awaited_rsp.push_back(fires[k]);
      end
      o = '0;
      o.kind = KIND_END;
      o.tasks_left = LEFT_W'(tbl_count);
      o.last = 1'b1;
      awaited_rsp.push_back(o);
    end
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_rsp(rsp_t got);
    rsp_t want;
    if (awaited_rsp.size() == 0) begin
      $display("%0t: response with none pending, expected nothing got %p", $time, got);
      n_errors++;
    end else begin
      want = awaited_rsp.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("fired_id", 32'(want.fired_id), 32'(got.fired_id));
      compare_field("call_count", want.call_count, got.call_count);
      compare_field("retired", 32'(want.retired), 32'(got.retired));
      compare_field("tasks_left", 32'(want.tasks_left), 32'(got.tasks_left));
      compare_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  // Driver: presents each request after a drawn gap and holds it until accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = pause_for(n_issued);
    end else if (!req_valid || req_ready) begin
      if (req_valid) gap_left = pause_for(n_issued);
      if (gap_left == 0 && cmd_backlog.size() != 0) begin
        req <= cmd_backlog.pop_front();
        req_valid <= 1'b1;
        n_issued++;
      end else begin
        req_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // Monitor: predicts on each accepted request, then checks any accepted response.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
      quiet_cycles = 0;
    end else begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (req_valid && req_ready) apply_command(req);
      if (rsp_valid && rsp_ready) begin
        check_rsp(rsp);
        n_rsp++;
        stall_left = pause_for(n_rsp);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rsp_ready <= (stall_left == 0);
    end
  end

  initial begin
    int pick;
    int n_rand;
    logic [31:0] t_us;
    req_t r;

    // Directed part: zero period, wrap of the clock, offset restart, both retire rules.
    cmd_backlog.push_back(scan_cmd(32'd0));
    cmd_backlog.push_back(add_cmd(32'd0, 8'hFF, 32'd0, 32'd0, 32'd0, 32'd0));
    cmd_backlog.push_back(add_cmd(32'hFFFF_FFF0, 8'h00, 32'hFFFF_FFFF, 32'd0,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_backlog.push_back(add_cmd(32'd10, 8'h03, 32'd100, 32'd1000, 32'd0, 32'd50));
    cmd_backlog.push_back(add_cmd(32'd20, 8'h04, 32'd10, 32'd0, 32'd2, 32'd0));
    cmd_backlog.push_back(scan_cmd(32'd30));
    cmd_backlog.push_back(scan_cmd(32'd1010));
    cmd_backlog.push_back(scan_cmd(32'd1200));
    cmd_backlog.push_back(scan_cmd(32'hFFFF_FFEF));
    for (int k = 0; k < 14; k++) begin
      cmd_backlog.push_back(add_cmd(32'd1300, 8'(8'h10 + k), 32'd0, 32'd0, 32'd1, 32'd0));
    end
    cmd_backlog.push_back(add_cmd(32'd1300, 8'hEE, 32'd5, 32'd0, 32'd0, 32'd0));
    cmd_backlog.push_back(scan_cmd(32'd1400));

    // Random part: mostly a sane time line with adds and scans, some noise and jumps.
    n_rand = 0;
    t_us = 32'd5000;
    while (n_rand < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 1) begin
        repeat ($urandom_range(2, 6)) begin
          t_us += $urandom_range(0, 20);
          cmd_backlog.push_back(workload_add(t_us));
          n_rand++;
        end
      end else if (pick <= 6) begin
        t_us += $urandom_range(0, 250);
        cmd_backlog.push_back(scan_cmd(t_us));
        n_rand++;
      end else if (pick == 7) begin
        cmd_backlog.push_back(workload_add(t_us));
        n_rand++;
      end else if (pick == 8) begin
        r = add_cmd($urandom, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
        r.command = 1'($urandom);
        cmd_backlog.push_back(r);
        n_rand++;
      end else begin
        t_us += $urandom;
        cmd_backlog.push_back(scan_cmd(t_us));
        n_rand++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (!(cmd_backlog.size() == 0 && !req_valid && awaited_rsp.size() == 0) &&
           quiet_cycles < WATCHDOG_LIMIT);

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      n_errors++;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (awaited_rsp.size() != 0) begin
      $display("%0t: %0d responses expected but never seen", $time, awaited_rsp.size());
      n_errors++;
    end

    $display("Sent %0d requests: %0d adds (%0d refused on a full table), %0d scans.",
             n_issued, n_adds, n_refused, n_scans);
    $display("Checked %0d responses, among them %0d fires and %0d retirements.",
             n_rsp, n_fires, n_retired);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
